/* design/npcs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package npcs_pkg;

  localparam int COLOR_W = 8;
  localparam int INDEX_W = 8;
  localparam int SQ_W    = 2 * COLOR_W;
  // Three squared 8-bit differences sum to at most 195075, which fits in 18 bits.
  localparam int DIST_W  = SQ_W + 2;
  localparam int BEST_W  = 24;

  localparam logic [BEST_W-1:0] START_DISTANCE = 24'd10000000;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic wr_en;     // store the accepted write transaction in the palette
    logic start;     // latch the query color and reset the running best
    logic issue;     // read the palette entry at the scan address
    logic load_out;  // copy the best index into the output register
  } npcs_cmd_t;

  typedef struct packed {
    logic last_addr;   // scan address points at the final palette entry
    logic pipe_empty;  // no read or distance stage holds a pending entry
  } npcs_status_t;

endpackage

`default_nettype wire

/* design/npcs_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module npcs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* design/npcs_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module npcs_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_mode,
  input  wire logic                 out_stall,
  input  wire npcs_pkg::npcs_status_t status,
  output logic                      in_stall,
  output logic                      out_valid,
  output npcs_pkg::npcs_cmd_t       cmd
);

  import npcs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_QUERY) begin
            cmd.start = 1'b1;
            state_nxt = ST_SCAN;
          end else begin
            cmd.wr_en = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (status.last_addr) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The result register must be free, or be emptied in this very cycle.
        if (status.pipe_empty && (!out_valid_r || !out_stall)) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* design/npcs_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module npcs_dp #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire npcs_pkg::npcs_cmd_t                cmd,
  input  wire logic [npcs_pkg::INDEX_W-1:0]       in_entry_index,
  input  wire logic [npcs_pkg::COLOR_W-1:0]       in_red,
  input  wire logic [npcs_pkg::COLOR_W-1:0]       in_green,
  input  wire logic [npcs_pkg::COLOR_W-1:0]       in_blue,
  input  wire logic                               in_skip_zero,
  output npcs_pkg::npcs_status_t                  status,
  output logic      [npcs_pkg::INDEX_W-1:0]       out_nearest_index
);

  import npcs_pkg::*;

  localparam int AW = $clog2(PALETTE_ENTRIES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_ENTRIES - 1);

  logic                 wr_en;
  logic [3*COLOR_W-1:0] rd_data;

  logic [COLOR_W-1:0]   qr_r, qg_r, qb_r;
  logic [AW-1:0]        addr_r;

  logic                 v0_r, v1_r;
  logic [AW-1:0]        idx0_r, idx1_r;
  logic [SQ_W-1:0]      sq_r_r, sq_g_r, sq_b_r;

  logic [COLOR_W-1:0]   d_red, d_green, d_blue;
  logic [DIST_W-1:0]    entry_dist;

  logic [BEST_W-1:0]    best_dist_r;
  logic [AW-1:0]        best_idx_r;
  logic [INDEX_W-1:0]   out_idx_r;

  // Writes to slots beyond the palette depth are dropped.
  assign wr_en = cmd.wr_en && ({1'b0, in_entry_index} < (INDEX_W + 1)'(PALETTE_ENTRIES));

  npcs_ram #(
    .WIDTH (3 * COLOR_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (wr_en),
    .waddr (in_entry_index[AW-1:0]),
    .wdata ({in_red, in_green, in_blue}),
    .re    (cmd.issue),
    .raddr (addr_r),
    .rdata (rd_data)
  );

  function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                 input logic [COLOR_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  assign d_red   = abs_diff(rd_data[3*COLOR_W-1:2*COLOR_W], qr_r);
  assign d_green = abs_diff(rd_data[2*COLOR_W-1:COLOR_W], qg_r);
  assign d_blue  = abs_diff(rd_data[COLOR_W-1:0], qb_r);

  assign entry_dist = DIST_W'(sq_r_r) + DIST_W'(sq_g_r) + DIST_W'(sq_b_r);

  // Scan address and query color.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      addr_r <= AW'(in_skip_zero);
      qr_r   <= in_red;
      qg_r   <= in_green;
      qb_r   <= in_blue;
    end else if (cmd.issue) begin
      addr_r <= addr_r + AW'(1);
    end
  end

  // Entry valid flags for the read and square stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= cmd.issue;
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    idx0_r <= addr_r;
    idx1_r <= idx0_r;
    sq_r_r <= SQ_W'(d_red) * SQ_W'(d_red);
    sq_g_r <= SQ_W'(d_green) * SQ_W'(d_green);
    sq_b_r <= SQ_W'(d_blue) * SQ_W'(d_blue);
  end

  // Running minimum; strict compare keeps the lowest index on a tie.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      best_dist_r <= START_DISTANCE;
      best_idx_r  <= '0;
    end else if (v1_r && (BEST_W'(entry_dist) < best_dist_r)) begin
      best_dist_r <= BEST_W'(entry_dist);
      best_idx_r  <= idx1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_idx_r <= INDEX_W'(best_idx_r);
    end
  end

  assign status.last_addr  = (addr_r == LAST_ADDR);
  assign status.pipe_empty = !v0_r && !v1_r;
  assign out_nearest_index = out_idx_r;

endmodule

`default_nettype wire

/* design/nearest_palette_color_search.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_stall   mode, entry_index, red, green, blue, skip_zero
// out_      output     out_valid / out_stall nearest_index
//
// A write transaction is stored in the palette in the cycle it is accepted and gives no result.
// A query scans the palette from entry skip_zero up to the last entry, one palette read per
// cycle through the single read port of the palette memory, then drains the read, square
// and compare stages and loads the result; the next transaction can be accepted once the
// result is loaded.
// Reset (rst_n low, synchronous) clears the controller and the pipeline valid flags only;
// palette contents stay undefined.
// While a query is in progress in_stall is high. A waiting result does not block new
// transactions; a finished scan only waits if the previous result is still held by out_stall.

module nearest_palette_color_search #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_mode,
  input  wire logic [npcs_pkg::INDEX_W-1:0] in_entry_index,
  input  wire logic [npcs_pkg::COLOR_W-1:0] in_red,
  input  wire logic [npcs_pkg::COLOR_W-1:0] in_green,
  input  wire logic [npcs_pkg::COLOR_W-1:0] in_blue,
  input  wire logic                         in_skip_zero,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [npcs_pkg::INDEX_W-1:0] out_nearest_index
);

  import npcs_pkg::*;

  npcs_cmd_t    cmd;
  npcs_status_t status;

  // The controller sequences the scan; it sees only the handshakes and the datapath status.
  npcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // The datapath holds the palette memory, the distance pipeline and the result register.
  npcs_dp #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_entry_index    (in_entry_index),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .in_skip_zero      (in_skip_zero),
    .status            (status),
    .out_nearest_index (out_nearest_index)
  );

  // The result is only taken once every scanned entry has passed the compare stage.
  a_load_after_drain : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> status.pipe_empty)
    else $error("result loaded while distance pipeline still busy");

  // A palette write never overlaps reads of an ongoing scan.
  a_write_when_quiet : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> (status.pipe_empty && !cmd.issue))
    else $error("palette written during a scan");

  // A loaded result is presented on the next cycle.
  a_load_shows_valid : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

  // An accepted query holds off further transactions while the scan runs.
  a_query_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_mode == MODE_QUERY)) |=> (in_stall && cmd.issue))
    else $error("query accepted but scan did not start");

endmodule

`default_nettype wire
